[sv/ctw_pkg.sv]
// Package with the word types and register codes of the cloth triangle wind force block.
`timescale 1ns / 1ps
package ctw_pkg;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIND_X = 2'd0,
        CFG_WIND_Y = 2'd1,
        CFG_WIND_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] c_x;
        logic signed [15:0] c_y;
        logic signed [15:0] c_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic               degenerate;
    } t_out_word;

    // Values that ride beside the root and quotient pipelines.
    typedef struct packed {
        logic               deg;
        logic signed [34:0] nx;
        logic signed [34:0] ny;
        logic signed [34:0] nz;
        logic signed [49:0] dot;
    } t_side;

endpackage

[sv/cloth_triangle_wind_force.sv]
// Top level of the cloth triangle wind force pipeline with its output buffer.
`timescale 1ns / 1ps
// Computes the wind force n * (n . w) / |n| on one cloth triangle, where n is the
// cross product of the triangle's edges and w the wind direction.
// The input channel (i_in_valid, o_in_ready, i_in_word) takes the three corners of
// one triangle per word. The output channel (o_out_valid, i_out_ready, o_out_word)
// returns the three saturated force components and the degenerate flag.
// The wind components are written through the configuration channel (i_cfg_valid,
// o_cfg_ready, i_cfg_index, i_cfg_data); the user must write them only while no
// triangle is in flight; the block does not enforce it. One word enters per cycle
// while o_in_ready is high, through a 32 stage square root and a 31 stage divider.
// Reset clears all valid bits and the wind registers to zero.
// A two word output buffer sits behind the pipeline. When it is full because the
// receiver stalls, the whole pipeline holds and o_in_ready drops, so nothing is
// lost or repeated; ready comes straight from the buffer fill count.
module cloth_triangle_wind_force (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  ctw_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output ctw_pkg::t_out_word          o_out_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ctw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);

    logic signed [15:0] r_wind_x;
    logic signed [15:0] r_wind_y;
    logic signed [15:0] r_wind_z;

    logic               ce;
    logic               f_valid;
    logic [63:0]        f_sumsq;
    ctw_pkg::t_side     f_side;
    logic               s_valid;
    logic [31:0]        s_root;
    ctw_pkg::t_side     s_side;
    logic               d_valid;
    logic [29:0]        d_quot;
    ctw_pkg::t_side     d_side;
    logic               k_valid;
    ctw_pkg::t_out_word k_word;

    ctw_pkg::t_out_word r_buf [2];
    logic               r_wr;
    logic               r_rd;
    logic [1:0]         r_cnt;
    logic               push;
    logic               pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind_x <= '0;
            r_wind_y <= '0;
            r_wind_z <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ctw_pkg::CFG_WIND_X: r_wind_x <= i_cfg_data;
                ctw_pkg::CFG_WIND_Y: r_wind_y <= i_cfg_data;
                ctw_pkg::CFG_WIND_Z: r_wind_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign ce         = (r_cnt != 2'd2);
    assign o_in_ready = ce;

    ctw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (i_in_valid),
        .i_word   (i_in_word),
        .i_wind_x (r_wind_x),
        .i_wind_y (r_wind_y),
        .i_wind_z (r_wind_z),
        .o_valid  (f_valid),
        .o_sumsq  (f_sumsq),
        .o_side   (f_side)
    );

    ctw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (f_valid),
        .i_x     (f_sumsq),
        .i_side  (f_side),
        .o_valid (s_valid),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    ctw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_valid),
        .i_root  (s_root),
        .i_side  (s_side),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_side  (d_side)
    );

    ctw_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (d_valid),
        .i_quot  (d_quot),
        .i_side  (d_side),
        .o_valid (k_valid),
        .o_word  (k_word)
    );

    assign push = ce & k_valid;
    assign pop  = (r_cnt != 2'd0) & i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= k_word;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_word  = r_buf[r_rd];

endmodule

[sv/ctw_front.sv]
// Front pipeline: edges, cross product, normalization, sum of squares and wind dot product.
`timescale 1ns / 1ps
module ctw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  ctw_pkg::t_in_word  i_word,
    input  logic signed [15:0] i_wind_x,
    input  logic signed [15:0] i_wind_y,
    input  logic signed [15:0] i_wind_z,
    output logic               o_valid,
    output logic [63:0]        o_sumsq,
    output ctw_pkg::t_side     o_side
);

    logic [8:0]         r_v;
    logic signed [16:0] r_e1 [3];
    logic signed [16:0] r_e2 [3];
    logic signed [33:0] r_p [6];
    logic signed [34:0] r_n [3];
    logic signed [34:0] r_nd [6][3];
    logic [33:0]        r_a4 [3];
    logic [33:0]        r_a5 [3];
    logic [33:0]        r_a6 [3];
    logic [33:0]        r_m;
    logic [4:0]         r_dg;
    logic               r_right;
    logic [4:0]         r_amt;
    logic signed [31:0] r_np [3];
    logic [30:0]        r_an [3];
    logic [61:0]        r_sq [3];
    logic signed [47:0] r_pw [3];
    logic [63:0]        r_sumsq;
    logic signed [49:0] r_dot;

    logic [33:0]        n_m;
    logic [5:0]         n_lead;
    logic               n_right;
    logic [4:0]         n_amt;
    logic [30:0]        n_an [3];
    logic signed [15:0] w [3];

    assign w[0] = i_wind_x;
    assign w[1] = i_wind_y;
    assign w[2] = i_wind_z;

    always_comb begin
        n_m = r_a4[0];
        if (r_a4[1] > n_m) begin
            n_m = r_a4[1];
        end
        if (r_a4[2] > n_m) begin
            n_m = r_a4[2];
        end
    end

    always_comb begin
        n_lead = '0;
        for (int i = 0; i < 34; i++) begin
            if (r_m[i]) begin
                n_lead = 6'(i);
            end
        end
        n_right = (n_lead > 6'd30);
        n_amt   = n_right ? 5'(n_lead - 6'd30) : 5'(6'd30 - n_lead);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_an[i] = r_right ? 31'(r_a6[i] >> r_amt) : 31'(r_a6[i] << r_amt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[7:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_e1[0] <= 17'(i_word.b_x) - 17'(i_word.a_x);
            r_e1[1] <= 17'(i_word.b_y) - 17'(i_word.a_y);
            r_e1[2] <= 17'(i_word.b_z) - 17'(i_word.a_z);
            r_e2[0] <= 17'(i_word.c_x) - 17'(i_word.a_x);
            r_e2[1] <= 17'(i_word.c_y) - 17'(i_word.a_y);
            r_e2[2] <= 17'(i_word.c_z) - 17'(i_word.a_z);

            r_p[0] <= 34'(r_e1[1]) * 34'(r_e2[2]);
            r_p[1] <= 34'(r_e1[2]) * 34'(r_e2[1]);
            r_p[2] <= 34'(r_e1[2]) * 34'(r_e2[0]);
            r_p[3] <= 34'(r_e1[0]) * 34'(r_e2[2]);
            r_p[4] <= 34'(r_e1[0]) * 34'(r_e2[1]);
            r_p[5] <= 34'(r_e1[1]) * 34'(r_e2[0]);

            for (int i = 0; i < 3; i++) begin
                r_n[i]     <= 35'(r_p[2*i]) - 35'(r_p[2*i+1]);
                r_nd[0][i] <= r_n[i];
                r_a4[i]    <= r_n[i] < 0 ? 34'(-r_n[i]) : 34'(r_n[i]);
                r_a5[i]    <= r_a4[i];
                r_a6[i]    <= r_a5[i];
                r_an[i]    <= n_an[i];
                r_np[i]    <= r_nd[2][i] < 0 ? -32'(n_an[i]) : 32'(n_an[i]);
                r_sq[i]    <= 62'(r_an[i]) * 62'(r_an[i]);
                r_pw[i]    <= 48'(r_np[i]) * 48'(w[i]);
            end
            for (int k = 1; k < 6; k++) begin
                r_nd[k] <= r_nd[k-1];
            end

            r_m     <= n_m;
            r_dg    <= {r_dg[3:0], (n_m == '0)};
            r_right <= n_right;
            r_amt   <= n_amt;
            r_sumsq <= 64'(r_sq[0]) + 64'(r_sq[1]) + 64'(r_sq[2]);
            r_dot   <= 50'(r_pw[0]) + 50'(r_pw[1]) + 50'(r_pw[2]);
        end
    end

    assign o_valid      = r_v[8];
    assign o_sumsq      = r_sumsq;
    assign o_side.deg   = r_dg[4];
    assign o_side.nx    = r_nd[5][0];
    assign o_side.ny    = r_nd[5][1];
    assign o_side.nz    = r_nd[5][2];
    assign o_side.dot   = r_dot;

endmodule

[sv/ctw_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module ctw_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_valid,
    input  logic [63:0]    i_x,
    input  ctw_pkg::t_side i_side,
    output logic           o_valid,
    output logic [31:0]    o_root,
    output ctw_pkg::t_side o_side
);

    localparam int NS = 32;

    logic           r_v    [NS];
    logic [63:0]    r_x    [NS];
    logic [63:0]    r_res  [NS];
    ctw_pkg::t_side r_side [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam logic [63:0] BIT = 64'(1) << (62 - 2*j);
        logic           v_in;
        logic [63:0]    x_in;
        logic [63:0]    res_in;
        logic [63:0]    trial;
        ctw_pkg::t_side side_in;
        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = i_x;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign x_in    = r_x[j-1];
            assign res_in  = r_res[j-1];
            assign side_in = r_side[j-1];
        end
        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_ce) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_side[j] <= side_in;
                if (x_in >= trial) begin
                    r_x[j]   <= x_in - trial;
                    r_res[j] <= (res_in >> 1) + BIT;
                end else begin
                    r_x[j]   <= x_in;
                    r_res[j] <= res_in >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = r_res[NS-1][31:0];
    assign o_side  = r_side[NS-1];

endmodule

[sv/ctw_div.sv]
// Pipelined restoring divider for the wind factor, one quotient bit per stage.
`timescale 1ns / 1ps
module ctw_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ce,
    input  logic           i_valid,
    input  logic [31:0]    i_root,
    input  ctw_pkg::t_side i_side,
    output logic           o_valid,
    output logic [29:0]    o_quot,
    output ctw_pkg::t_side o_side
);

    localparam int NQ = 30;

    logic           r_pv;
    logic [63:0]    r_prem;
    logic [31:0]    r_pd;
    ctw_pkg::t_side r_pside;

    logic           r_v    [NQ];
    logic [63:0]    r_rem  [NQ];
    logic [31:0]    r_d    [NQ];
    logic [29:0]    r_q    [NQ];
    ctw_pkg::t_side r_side [NQ];

    logic [48:0]    dot_mag;

    assign dot_mag = i_side.dot < 0 ? 49'(-i_side.dot) : 49'(i_side.dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_ce) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prem  <= 64'(dot_mag) << 12;
            r_pd    <= i_root;
            r_pside <= i_side;
        end
    end

    for (genvar k = 0; k < NQ; k++) begin : g_stage
        logic           v_in;
        logic [63:0]    rem_in;
        logic [31:0]    d_in;
        logic [29:0]    q_in;
        logic [63:0]    sub;
        ctw_pkg::t_side side_in;
        if (k == 0) begin : g_first
            assign v_in    = r_pv;
            assign rem_in  = r_prem;
            assign d_in    = r_pd;
            assign q_in    = '0;
            assign side_in = r_pside;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign d_in    = r_d[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end
        assign sub = 64'(d_in) << (NQ - 1 - k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ce) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_d[k]    <= d_in;
                r_side[k] <= side_in;
                if (rem_in >= sub) begin
                    r_rem[k] <= rem_in - sub;
                    r_q[k]   <= {q_in[28:0], 1'b1};
                end else begin
                    r_rem[k] <= rem_in;
                    r_q[k]   <= {q_in[28:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[NQ-1];
    assign o_quot  = r_q[NQ-1];
    assign o_side  = r_side[NQ-1];

endmodule

[sv/ctw_scale.sv]
// Output stages: scales the normal by the wind factor, saturates to 32 bits and gives zero for a degenerate triangle.
`timescale 1ns / 1ps
module ctw_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  logic [29:0]        i_quot,
    input  ctw_pkg::t_side     i_side,
    output logic               o_valid,
    output ctw_pkg::t_out_word o_word
);

    logic               r_v1;
    logic               r_v2;
    logic               r_deg1;
    logic [2:0]         r_neg;
    logic [46:0]        r_plo [3];
    logic [46:0]        r_phi [3];
    logic signed [31:0] r_f [3];
    logic               r_deg2;

    logic signed [34:0] n [3];
    logic [33:0]        nmag [3];
    logic [63:0]        prod [3];
    logic [51:0]        t [3];
    logic signed [31:0] f [3];

    assign n[0] = i_side.nx;
    assign n[1] = i_side.ny;
    assign n[2] = i_side.nz;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nmag[i] = n[i] < 0 ? 34'(-n[i]) : 34'(n[i]);
            prod[i] = (64'(r_phi[i]) << 17) + 64'(r_plo[i]);
            t[i]    = 52'(prod[i] >> 12);
            if (r_deg1) begin
                f[i] = '0;
            end else if (r_neg[i]) begin
                f[i] = (t[i] > 52'h0_0000_8000_0000) ? 32'sh8000_0000 : -32'(t[i]);
            end else begin
                f[i] = (t[i] > 52'h0_0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(t[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= (n[i] < 0) ^ (i_side.dot < 0);
                r_plo[i] <= 47'(nmag[i][16:0]) * 47'(i_quot);
                r_phi[i] <= 47'(nmag[i][33:17]) * 47'(i_quot);
                r_f[i]   <= f[i];
            end
            r_deg1 <= i_side.deg;
            r_deg2 <= r_deg1;
        end
    end

    assign o_valid           = r_v2;
    assign o_word.force_x    = r_f[0];
    assign o_word.force_y    = r_f[1];
    assign o_word.force_z    = r_f[2];
    assign o_word.degenerate = r_deg2;

endmodule
